@@ rtl/core/bpe_pkg.sv @@
// shared types, constants and helpers for the ball position extrapolator
package bpe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int A_W       = 28;
  localparam int OUT_W     = 13;

  localparam logic signed [63:0] OUT_MAX = 64'sd4095;
  localparam logic signed [63:0] OUT_MIN = -64'sd4096;

  localparam logic [63:0] A_MAG_POS = 64'd134217727;
  localparam logic [63:0] A_MAG_NEG = 64'd134217728;

  localparam logic signed [A_W-1:0] A_MAX_Q = 28'sh7ffffff;
  localparam logic signed [A_W-1:0] A_MIN_Q = 28'sh8000000;
  localparam logic signed [A_W-1:0] A_ONE   = 28'sd65536;
  localparam logic signed [A_W-1:0] A_TINY  = 28'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ADIV, S_ASET, S_BMUL, S_BSUB, S_MUL, S_SUM,
    S_Y, S_NUM, S_XGO, S_XDIV, S_XSET, S_DIST, S_CHK, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_PREP, OP_ASET, OP_MUL, OP_BSUB, OP_SUM,
    OP_Y, OP_NUM, OP_XGO, OP_XSET, OP_DIST, OP_STEP, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_go;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic dy_zero;
    logic far;
    logic last;
    logic out_full;
  } stat_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v;
    if (v > OUT_MAX) s = OUT_MAX;
    if (v < OUT_MIN) s = OUT_MIN;
    return OUT_W'(s);
  endfunction

endpackage

@@ rtl/core/bpe_in_if.sv @@
// object position channel: current and previous position plus lead distance
interface bpe_in_if #(parameter int COORD_BITS = 10) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [COORD_BITS-1:0] lead_distance;

  modport source (output valid, cur_x, cur_y, prev_x, prev_y, lead_distance, input ready);
  modport sink (input valid, cur_x, cur_y, prev_x, prev_y, lead_distance, output ready);
endinterface

@@ rtl/core/bpe_out_if.sv @@
// predicted position channel
interface bpe_out_if import bpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pred_x;
  logic signed [OUT_W-1:0] pred_y;

  modport source (output valid, pred_x, pred_y, input ready);
  modport sink (input valid, pred_x, pred_y, output ready);
endinterface

@@ rtl/core/ball_position_extrapolator.sv @@
// top level: predicts a point along the line through two object positions
//
//   channel  role    payload
//   obj      sink    cur_x, cur_y, prev_x, prev_y, lead_distance
//   pred     source  pred_x, pred_y
//
// one transaction on obj gives one transaction on pred; items are handled one at a time
// setup forms the slope with the shared divider producing one quotient bit per cycle,
// and skips the divider when the y difference is zero
// each line step again uses the divider producing one quotient bit per cycle; its x
// quotient is XW = clog2(2**COORD_BITS + MAX_STEPS) + 1 bits wide, 12 by default
// an item takes up to MAX_STEPS + 1 line steps
// rst is synchronous; a finished result waits in the output register while the next
// transaction on obj is taken, and the next result stalls until that register is free
module ball_position_extrapolator import bpe_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int MAX_STEPS  = 1024
) (
  input logic        clk,
  input logic        rst,
  bpe_in_if.sink     obj,
  bpe_out_if.source  pred
);

  cmd_t  cmd;
  stat_t stat;

  bpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .obj_valid (obj.valid),
    .obj_ready (obj.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpe_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cur_x         (obj.cur_x),
    .cur_y         (obj.cur_y),
    .prev_x        (obj.prev_x),
    .prev_y        (obj.prev_y),
    .lead_distance (obj.lead_distance),
    .pred_valid    (pred.valid),
    .pred_ready    (pred.ready),
    .pred_x        (pred.pred_x),
    .pred_y        (pred.pred_y)
  );

endmodule

@@ rtl/core/bpe_div.sv @@
// shared restoring divider on magnitudes, one quotient bit per cycle
module bpe_div #(
  parameter int DVW = 28,
  parameter int QM  = 26
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DVW+QM-1:0]          dividend,
  input  logic [DVW-1:0]             divisor,
  input  logic [$clog2(QM+1)-1:0]    iters,
  output logic                       busy,
  output logic [QM-1:0]              quot
);

  localparam int RW = DVW + QM;
  localparam int CW = $clog2(QM + 1);

  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= RW'(divisor) << (iters - CW'(1));
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quot <= {quot[QM-2:0], ge};
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with zero count");
`endif

endmodule

@@ rtl/core/bpe_ctrl.sv @@
// sequencer for setup, the stepping loop and result hand-off
module bpe_ctrl import bpe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  obj_valid,
  output logic  obj_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (obj_valid) state_next = S_PREP;
      S_PREP: state_next = stat.dy_zero ? S_BMUL : S_ADIV;
      S_ADIV: if (!stat.div_busy) state_next = S_ASET;
      S_ASET: state_next = S_BMUL;
      S_BMUL: state_next = S_BSUB;
      S_BSUB: state_next = S_MUL;
      S_MUL:  state_next = S_SUM;
      S_SUM:  state_next = S_Y;
      S_Y:    state_next = S_NUM;
      S_NUM:  state_next = S_XGO;
      S_XGO:  state_next = S_XDIV;
      S_XDIV: if (!stat.div_busy) state_next = S_XSET;
      S_XSET: state_next = S_DIST;
      S_DIST: state_next = S_CHK;
      S_CHK:  state_next = (stat.far || stat.last) ? S_DONE : S_MUL;
      S_DONE: if (!stat.out_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    obj_ready  = 1'b0;
    cmd.op     = OP_NOP;
    cmd.div_go = 1'b0;
    case (state)
      S_IDLE: begin
        obj_ready = 1'b1;
        if (obj_valid) cmd.op = OP_LOAD;
      end
      S_PREP: begin
        cmd.op     = OP_PREP;
        cmd.div_go = !stat.dy_zero;
      end
      S_ASET: cmd.op = OP_ASET;
      S_BMUL: cmd.op = OP_MUL;
      S_BSUB: cmd.op = OP_BSUB;
      S_MUL:  cmd.op = OP_MUL;
      S_SUM:  cmd.op = OP_SUM;
      S_Y:    cmd.op = OP_Y;
      S_NUM:  cmd.op = OP_NUM;
      S_XGO: begin
        cmd.op     = OP_XGO;
        cmd.div_go = 1'b1;
      end
      S_XSET: cmd.op = OP_XSET;
      S_DIST: cmd.op = OP_DIST;
      S_CHK:  cmd.op = (stat.far || stat.last) ? OP_NOP : OP_STEP;
      S_DONE: cmd.op = stat.out_full ? OP_NOP : OP_OUT;
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ rtl/core/bpe_dp.sv @@
// datapath: slope, intercept, line stepping, distance test, output register
module bpe_dp import bpe_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int MAX_STEPS  = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic [COORD_BITS-1:0]   cur_x,
  input  logic [COORD_BITS-1:0]   cur_y,
  input  logic [COORD_BITS-1:0]   prev_x,
  input  logic [COORD_BITS-1:0]   prev_y,
  input  logic [COORD_BITS-1:0]   lead_distance,
  output logic                    pred_valid,
  input  logic                    pred_ready,
  output logic signed [OUT_W-1:0] pred_x,
  output logic signed [OUT_W-1:0] pred_y
);

  localparam int C   = COORD_BITS;
  localparam int XW  = $clog2((1 << C) + MAX_STEPS) + 1;
  localparam int PW  = A_W + XW + 1;
  localparam int YW  = PW - FRAC_BITS;
  localparam int QA  = C + FRAC_BITS;
  localparam int QM  = (QA > XW) ? QA : XW;
  localparam int RW  = A_W + QM;
  localparam int CW  = $clog2(QM + 1);
  localparam int KW  = $clog2(MAX_STEPS + 1);

  logic [C-1:0]              cx, cy, lead;
  logic signed [C:0]         dx, dy;
  logic signed [A_W-1:0]     a;
  logic                      a_neg;
  logic                      dir_up;
  logic [2*C-1:0]            lim2;
  logic signed [XW-1:0]      xs;
  logic [KW-1:0]             k;
  logic signed [PW-1:0]      prod, b, acc, num;
  logic signed [YW-1:0]      y;
  logic signed [XW:0]        x;
  logic                      far;
  logic signed [OUT_W-1:0]   px_q, py_q;

  logic signed [C:0]         dx_eff;
  logic [C:0]                dx_mag, dy_mag;
  logic [A_W-1:0]            a_mag;
  logic [PW-1:0]             num_mag;
  logic signed [A_W+XW-1:0]  mul_c;
  logic                      rnd;
  logic signed [XW:0]        xq_pos;
  logic                      x_neg;
  logic [63:0]               q64;
  logic signed [XW+1:0]      ex;
  logic signed [YW:0]        ey;
  logic [XW+1:0]             ex_mag;
  logic [YW:0]               ey_mag;
  logic [2*C-1:0]            ex_sq, ey_sq;
  logic [2*C:0]              sq_sum;
  logic                      far_c;

  logic                      div_busy;
  logic [QM-1:0]             quot;
  logic [RW-1:0]             div_num;
  logic [A_W-1:0]            div_den;
  logic [CW-1:0]             div_iters;

  assign dx_eff  = (dx == '0) ? (C+1)'(1) : dx;
  assign dx_mag  = dx_eff[C] ? (C+1)'(-dx_eff) : (C+1)'(dx_eff);
  assign dy_mag  = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
  assign a_mag   = a[A_W-1] ? A_W'(-a) : A_W'(a);
  assign num_mag = num[PW-1] ? PW'(-num) : PW'(num);
  assign mul_c   = (A_W+XW)'(a) * (A_W+XW)'(xs);
  assign rnd     = acc[PW-1] && (acc[FRAC_BITS-1:0] != '0);
  assign xq_pos  = $signed({1'b0, quot[XW-1:0]});
  assign x_neg   = num[PW-1] ^ a[A_W-1];
  assign q64     = 64'(quot);

  // distance from the current point; an offset that clears the coordinate range counts as far
  assign ex      = (XW+2)'(x) - (XW+2)'($signed({1'b0, cx}));
  assign ey      = (YW+1)'(y) - (YW+1)'($signed({1'b0, cy}));
  assign ex_mag  = ex[XW+1] ? (XW+2)'(-ex) : (XW+2)'(ex);
  assign ey_mag  = ey[YW] ? (YW+1)'(-ey) : (YW+1)'(ey);
  assign ex_sq   = (2*C)'(ex_mag[C-1:0]) * (2*C)'(ex_mag[C-1:0]);
  assign ey_sq   = (2*C)'(ey_mag[C-1:0]) * (2*C)'(ey_mag[C-1:0]);
  assign sq_sum  = (2*C+1)'(ex_sq) + (2*C+1)'(ey_sq);
  assign far_c   = (ex_mag[XW+1:C] != '0) || (ey_mag[YW:C] != '0) ||
                   (sq_sum >= (2*C+1)'(lim2));

  always_comb begin
    case (cmd.op)
      OP_PREP: begin
        div_num   = RW'({dy_mag, {FRAC_BITS{1'b0}}});
        div_den   = A_W'(dx_mag);
        div_iters = CW'(QA);
      end
      default: begin
        div_num   = RW'(num_mag);
        div_den   = a_mag;
        div_iters = CW'(XW);
      end
    endcase
  end

  bpe_div #(
    .DVW (A_W),
    .QM  (QM)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .iters    (div_iters),
    .busy     (div_busy),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cx   <= cur_x;
        cy   <= cur_y;
        lead <= lead_distance;
        dx   <= $signed({1'b0, prev_x}) - $signed({1'b0, cur_x});
        dy   <= $signed({1'b0, prev_y}) - $signed({1'b0, cur_y});
        xs   <= XW'($signed({1'b0, cur_x}));
        k    <= '0;
      end
      OP_PREP: begin
        dir_up <= dx_eff[C];
        a_neg  <= dy[C] ^ dx_eff[C];
        lim2   <= (2*C)'(lead) * (2*C)'(lead);
        if (dy == '0) begin
          a <= A_ONE;
        end
      end
      OP_ASET: begin
        if (quot == '0) begin
          a <= A_TINY;
        end else if (a_neg) begin
          a <= (q64 > A_MAG_NEG) ? A_MIN_Q : -$signed(A_W'(quot));
        end else begin
          a <= (q64 > A_MAG_POS) ? A_MAX_Q : $signed(A_W'(quot));
        end
      end
      OP_MUL:  prod <= PW'(mul_c);
      OP_BSUB: b    <= $signed(PW'({cy, {FRAC_BITS{1'b0}}})) - prod;
      OP_SUM:  acc  <= prod + b;
      OP_Y:    y    <= $signed(acc[PW-1:FRAC_BITS] + YW'(rnd));
      OP_NUM:  num  <= $signed({y, {FRAC_BITS{1'b0}}}) - b;
      OP_XSET: x    <= x_neg ? -xq_pos : xq_pos;
      OP_DIST: far  <= far_c;
      OP_STEP: begin
        xs <= dir_up ? xs + XW'(1) : xs - XW'(1);
        k  <= k + KW'(1);
      end
      OP_OUT: begin
        px_q <= sat_out(64'(x));
        py_q <= sat_out(64'(y));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      pred_valid <= 1'b1;
    end else if (pred_ready) begin
      pred_valid <= 1'b0;
    end
  end

  assign pred_x        = px_q;
  assign pred_y        = py_q;
  assign stat.div_busy = div_busy;
  assign stat.dy_zero  = (dy == '0);
  assign stat.far      = far;
  assign stat.last     = (k == KW'(MAX_STEPS));
  assign stat.out_full = pred_valid;

`ifndef NO_ASSERTIONS
  a_div_idle: assert property (@(posedge clk) disable iff (rst) cmd.div_go |-> !div_busy)
    else $error("divider restarted while busy");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> !pred_valid)
    else $error("result register overwritten");
  a_slope_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SUM) |-> a != '0)
    else $error("zero slope in stepping loop");
`endif

endmodule
